FILE: hw/rtl/isms_pkg.sv
// Shared types and constants for the Ising Metropolis site update block.
package isms_pkg;

    localparam int STORE_AW   = 12;              // spin store address width
    localparam int STORE_CW   = STORE_AW + 1;    // clear counter, holds the depth
    localparam int NADDR_W    = 32;              // neighbour index width before range check
    localparam int WEIGHT_W   = 33;
    localparam int RAND_W     = 32;
    localparam int KIND_W     = 2;
    localparam int TOTAL_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int RECIP_SHIFT = 24;             // reciprocal scaling for divide by side
    localparam int PROD_W     = 36;

    localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_ONE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_TWO   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_THREE = 2'd2;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 33'h1_0000_0000;

    typedef struct packed {
        logic [WEIGHT_W-1:0] w_one;
        logic [WEIGHT_W-1:0] w_two;
        logic [WEIGHT_W-1:0] w_three;
    } weights_t;

    typedef struct packed {
        logic                en;
        logic                we;
        logic [STORE_AW-1:0] addr;
        logic                wdata;
    } mem_req_t;

endpackage

FILE: hw/rtl/isms_if.sv
// Valid/ready channel interfaces for update items and results.
interface isms_item_if;
    logic                          valid;
    logic                          ready;
    logic [isms_pkg::KIND_W-1:0]   kind;
    logic [isms_pkg::STORE_AW-1:0] site_index;
    logic [isms_pkg::RAND_W-1:0]   random_fraction;
    logic                          load_value;

    modport source (output valid, kind, site_index, random_fraction, load_value, input ready);
    modport sink   (input valid, kind, site_index, random_fraction, load_value, output ready);
endinterface

interface isms_result_if;
    logic                               valid;
    logic                               ready;
    logic                               accepted;
    logic                               spin_after;
    logic signed [isms_pkg::TOTAL_W-1:0] neighbour_total;

    modport source (output valid, accepted, spin_after, neighbour_total, input ready);
    modport sink   (input valid, accepted, spin_after, neighbour_total, output ready);
endinterface

FILE: hw/rtl/isms_spin_store.sv
// Single-port 4096 x 1 spin memory with a set-to-plus-one pass after reset.
module isms_spin_store
(
    input  logic               clk,
    input  logic               rst_n,
    input  isms_pkg::mem_req_t req,
    output logic               rdata,
    output logic               busy
);

    localparam int DEPTH = 2 ** isms_pkg::STORE_AW;

    logic                          mem [DEPTH];
    logic [isms_pkg::STORE_CW-1:0] clr_cnt_reg;
    logic [isms_pkg::STORE_CW-1:0] clr_cnt_next;
    logic                          rdata_reg;

    // top bit of the counter marks the pass as finished
    assign busy         = !clr_cnt_reg[isms_pkg::STORE_AW];
    assign clr_cnt_next = busy ? clr_cnt_reg + 1'b1 : clr_cnt_reg;
    assign rdata        = rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy)
        begin
            mem[clr_cnt_reg[isms_pkg::STORE_AW-1:0]] <= 1'b1;
        end
        else if (req.en && req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.en && !req.we)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

endmodule

FILE: hw/rtl/isms_seq.sv
// Sequencer and shared datapath: coordinate split, neighbour reads, Metropolis decision.
module isms_seq
#(
    parameter int DIMENSIONS  = 2,
    parameter int SIDE_LENGTH = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    isms_item_if.sink           item,
    isms_result_if.source       result,
    input  isms_pkg::weights_t  weights,
    output isms_pkg::mem_req_t  mem_req,
    input  logic                mem_rdata,
    input  logic                store_busy
);

    localparam int AW = isms_pkg::STORE_AW;
    localparam int NW = isms_pkg::NADDR_W;
    localparam int TW = isms_pkg::TOTAL_W;
    localparam int CW = $clog2(SIDE_LENGTH);
    localparam int RECIP = (2 ** isms_pkg::RECIP_SHIFT + SIDE_LENGTH - 1) / SIDE_LENGTH;

    function automatic int calc_sites();
        longint v;
        v = 1;
        for (int d = 0; d < DIMENSIONS; d++)
        begin
            v = v * SIDE_LENGTH;
            if (v > 2 ** AW)
            begin
                v = 2 ** AW;
            end
        end
        return int'(v);
    endfunction

    localparam logic [isms_pkg::STORE_CW-1:0] SITE_LIMIT = isms_pkg::STORE_CW'(calc_sites());

    localparam logic [NW-1:0] STRIDE_0 = NW'(1);
    localparam logic [NW-1:0] STRIDE_1 = NW'(SIDE_LENGTH);
    localparam logic [NW-1:0] STRIDE_2 = NW'(SIDE_LENGTH * SIDE_LENGTH);
    localparam logic [NW-1:0] WRAP_0   = NW'(SIDE_LENGTH - 1);
    localparam logic [NW-1:0] WRAP_1   = NW'((SIDE_LENGTH - 1) * SIDE_LENGTH);
    localparam logic [NW-1:0] WRAP_2   = NW'((SIDE_LENGTH - 1) * SIDE_LENGTH * SIDE_LENGTH);
    localparam logic [CW-1:0] COORD_MAX = CW'(SIDE_LENGTH - 1);
    localparam logic [1:0]    DIM_LAST  = 2'(DIMENSIONS - 1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SITE = 4'd1;
    localparam logic [3:0] ST_RD   = 4'd2;
    localparam logic [3:0] ST_MUL  = 4'd3;
    localparam logic [3:0] ST_DIG  = 4'd4;
    localparam logic [3:0] ST_UP   = 4'd5;
    localparam logic [3:0] ST_DN   = 4'd6;
    localparam logic [3:0] ST_DEC  = 4'd7;
    localparam logic [3:0] ST_DONE = 4'd8;

    logic [3:0]  state_reg;
    logic [3:0]  state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    logic [isms_pkg::KIND_W-1:0] kind_reg;
    logic [AW-1:0]               site_reg;
    logic [isms_pkg::RAND_W-1:0] rnd_reg;
    logic                        load_reg;
    logic [AW-1:0]               rem_reg;
    logic [isms_pkg::PROD_W-1:0] prod_reg;
    logic [CW-1:0]               coord_reg;
    logic [1:0]                  dim_reg;
    logic signed [TW-1:0]        total_reg;
    logic                        spin_reg;
    logic [AW-1:0]               dn_addr_reg;
    logic                        up_oob_reg;
    logic                        dn_oob_reg;
    logic                        res_acc_reg;
    logic                        res_spin_reg;
    logic signed [TW-1:0]        res_total_reg;
    logic                        out_acc_reg;
    logic                        out_spin_reg;
    logic signed [TW-1:0]        out_total_reg;

    logic                        take;
    logic                        out_load;
    logic                        in_range;
    logic [AW-1:0]               quot;
    logic [AW-1:0]               qside;
    logic [NW-1:0]               stride;
    logic [NW-1:0]               wrap;
    logic [NW-1:0]               up_addr;
    logic [NW-1:0]               dn_addr;
    logic signed [TW-1:0]        up_term;
    logic signed [TW-1:0]        dn_term;
    logic signed [TW-1:0]        total_fin;
    logic signed [TW-1:0]        k_val;
    logic                        k_pos;
    logic [isms_pkg::WEIGHT_W-1:0] weight;
    logic                        flip;

    assign take     = item.valid && item.ready;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);
    assign in_range = {1'b0, site_reg} < SITE_LIMIT;

    assign item.ready             = (state_reg == ST_IDLE) && !store_busy;
    assign result.valid           = out_valid_reg;
    assign result.accepted        = out_acc_reg;
    assign result.spin_after      = out_spin_reg;
    assign result.neighbour_total = out_total_reg;

    // divide by side through the reciprocal, exact for 12-bit dividends
    assign quot  = prod_reg[isms_pkg::RECIP_SHIFT +: AW];
    assign qside = AW'(24'(quot) * 24'(SIDE_LENGTH));

    always_comb
    begin
        unique case (dim_reg)
            2'd0:
            begin
                stride = STRIDE_0;
                wrap   = WRAP_0;
            end
            2'd1:
            begin
                stride = STRIDE_1;
                wrap   = WRAP_1;
            end
            default:
            begin
                stride = STRIDE_2;
                wrap   = WRAP_2;
            end
        endcase
    end

    assign up_addr = (coord_reg == COORD_MAX) ? NW'(site_reg) - wrap : NW'(site_reg) + stride;
    assign dn_addr = (coord_reg == '0) ? NW'(site_reg) + wrap : NW'(site_reg) - stride;

    // neighbours beyond the store count as +1
    assign up_term = (up_oob_reg || mem_rdata) ? TW'(1) : -TW'(1);
    assign dn_term = (dn_oob_reg || mem_rdata) ? TW'(1) : -TW'(1);

    assign total_fin = total_reg + dn_term;
    assign k_val     = spin_reg ? total_fin : -total_fin;
    assign k_pos     = !k_val[TW-1] && (k_val != '0);

    always_comb
    begin
        unique case (k_val[2:1])
            2'd1:    weight = weights.w_one;
            2'd2:    weight = weights.w_two;
            default: weight = weights.w_three;
        endcase
    end

    assign flip = !k_pos || ({1'b0, rnd_reg} <= weight);

    always_comb
    begin
        state_next = state_reg;
        mem_req    = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    state_next = ST_SITE;
                end
            end
            ST_SITE:
            begin
                if (!in_range)
                begin
                    state_next = ST_DONE;
                end
                else if (kind_reg == isms_pkg::KIND_LOAD)
                begin
                    mem_req.en    = 1'b1;
                    mem_req.we    = 1'b1;
                    mem_req.addr  = site_reg;
                    mem_req.wdata = load_reg;
                    state_next    = ST_DONE;
                end
                else
                begin
                    mem_req.en   = 1'b1;
                    mem_req.addr = site_reg;
                    state_next   = (kind_reg == isms_pkg::KIND_UPDATE) ? ST_MUL : ST_RD;
                end
            end
            ST_RD:   state_next = ST_DONE;
            ST_MUL:  state_next = ST_DIG;
            ST_DIG:  state_next = ST_UP;
            ST_UP:
            begin
                mem_req.en   = (up_addr[NW-1:AW] == '0);
                mem_req.addr = up_addr[AW-1:0];
                state_next   = ST_DN;
            end
            ST_DN:
            begin
                mem_req.en   = !dn_oob_reg;
                mem_req.addr = dn_addr_reg;
                state_next   = (dim_reg == DIM_LAST) ? ST_DEC : ST_MUL;
            end
            ST_DEC:
            begin
                mem_req.en    = flip;
                mem_req.we    = 1'b1;
                mem_req.addr  = site_reg;
                mem_req.wdata = !spin_reg;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                kind_reg  <= item.kind;
                site_reg  <= item.site_index;
                rnd_reg   <= item.random_fraction;
                load_reg  <= item.load_value;
                rem_reg   <= item.site_index;
                dim_reg   <= '0;
                total_reg <= '0;
            end
            ST_SITE:
            begin
                res_acc_reg   <= 1'b0;
                res_spin_reg  <= in_range && load_reg;
                res_total_reg <= '0;
            end
            ST_RD:
            begin
                res_spin_reg <= mem_rdata;
            end
            ST_MUL:
            begin
                prod_reg <= isms_pkg::PROD_W'(rem_reg) * isms_pkg::PROD_W'(RECIP);
                if (dim_reg == '0)
                begin
                    spin_reg <= mem_rdata;
                end
                else
                begin
                    total_reg <= total_reg + dn_term;
                end
            end
            ST_DIG:
            begin
                coord_reg <= CW'(rem_reg - qside);
                rem_reg   <= quot;
            end
            ST_UP:
            begin
                up_oob_reg  <= (up_addr[NW-1:AW] != '0);
                dn_oob_reg  <= (dn_addr[NW-1:AW] != '0);
                dn_addr_reg <= dn_addr[AW-1:0];
            end
            ST_DN:
            begin
                total_reg <= total_reg + up_term;
                dim_reg   <= dim_reg + 1'b1;
            end
            ST_DEC:
            begin
                res_acc_reg   <= flip;
                res_spin_reg  <= flip ? !spin_reg : spin_reg;
                res_total_reg <= total_fin;
            end
            default:
            begin
                if (out_load)
                begin
                    out_acc_reg   <= res_acc_reg;
                    out_spin_reg  <= res_spin_reg;
                    out_total_reg <= res_total_reg;
                end
            end
        endcase
    end

endmodule

FILE: hw/rtl/ising_metropolis_site_update_top.sv
// Top level of the single-spin-flip Metropolis Ising lattice updater.
//
// Holds a periodic lattice of SIDE_LENGTH^DIMENSIONS spins (at most 4096
// stored) in one single-port 4096 x 1 memory. Items arrive on "item", one
// result per item leaves on "result"; each is a valid/ready transfer. The
// block works on one item at a time and drops item.ready until that item's
// result is in the output register; the output register lets the next item
// be taken while a result still waits. An update runs ST_SITE, then ST_MUL,
// ST_DIG, ST_UP and ST_DN per dimension, then ST_DEC and ST_DONE; a read runs
// ST_SITE, ST_RD, ST_DONE; a load or an out-of-lattice site ST_SITE, ST_DONE.
// Each dimension costs four steps: one reciprocal multiply to split off
// the site coordinate, one remainder step, then the two neighbour reads
// on the single memory port; site read and write-back share that port.
// After reset the memory is set to all +1, one entry a cycle, so item.ready
// stays low until every entry is written; configuration writes are taken at
// any time. Weights are 33-bit fractions of 2^32; a weight of 2^32 always
// accepts. Write them only while no item is in flight.
module ising_metropolis_site_update_top
#(
    parameter int DIMENSIONS  = 2,
    parameter int SIDE_LENGTH = 64
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    isms_item_if.sink                           item,
    isms_result_if.source                       result,
    input  logic                                cfg_we,
    input  logic [isms_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [isms_pkg::WEIGHT_W-1:0]       cfg_data
);

    isms_pkg::weights_t weights_reg;
    isms_pkg::weights_t weights_next;
    isms_pkg::mem_req_t mem_req;
    logic               mem_rdata;
    logic               store_busy;

    // register file write; an index past the list is ignored
    always_comb
    begin
        weights_next = weights_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                isms_pkg::CFG_WEIGHT_ONE:   weights_next.w_one   = cfg_data;
                isms_pkg::CFG_WEIGHT_TWO:   weights_next.w_two   = cfg_data;
                isms_pkg::CFG_WEIGHT_THREE: weights_next.w_three = cfg_data;
                default:                    weights_next = weights_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weights_reg.w_one   <= isms_pkg::WEIGHT_RESET;
            weights_reg.w_two   <= isms_pkg::WEIGHT_RESET;
            weights_reg.w_three <= isms_pkg::WEIGHT_RESET;
        end
        else
        begin
            weights_reg <= weights_next;
        end
    end

    // spin memory, cleared to +1 after reset
    isms_spin_store u_store
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (mem_rdata),
        .busy  (store_busy)
    );

    // sequencer with the shared divide/address unit and decision logic
    isms_seq
    #(
        .DIMENSIONS  (DIMENSIONS),
        .SIDE_LENGTH (SIDE_LENGTH)
    )
    u_seq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .result     (result),
        .weights    (weights_reg),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata),
        .store_busy (store_busy)
    );

endmodule

FILE: hw/rtl/isms_checker.sv
// Port-level assertions for the Metropolis site updater, bound to the top level.
module isms_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               item_valid,
    input logic                               item_ready,
    input logic                               result_valid,
    input logic                               result_ready,
    input logic                               accepted,
    input logic                               spin_after,
    input logic signed [isms_pkg::TOTAL_W-1:0] neighbour_total
);

    // one item at a time: no transfer in the cycle after one
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item ready right after a transfer");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    // an even number of +-1 terms, never below -6
    a_total_even: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !neighbour_total[0] && (neighbour_total[3:0] != 4'b1000))
        else $error("neighbour total odd or out of range");

    // a rejected flip means spin and field agree in sign
    a_reject_sign: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !accepted && (neighbour_total != 0)
            |-> (spin_after == !neighbour_total[isms_pkg::TOTAL_W-1]))
        else $error("rejected update against the field sign");

    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !item_ready)
        else $error("item ready during the clearing pass");

endmodule

bind ising_metropolis_site_update_top isms_checker u_isms_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item.valid),
    .item_ready      (item.ready),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .accepted        (result.accepted),
    .spin_after      (result.spin_after),
    .neighbour_total (result.neighbour_total)
);
